// ----- hdl/menu_key_autorepeat_unit_assert.svh -----
// Assertion helpers for the autorepeat unit
`ifndef MENU_KEY_AUTOREPEAT_UNIT_ASSERT_SVH
`define MENU_KEY_AUTOREPEAT_UNIT_ASSERT_SVH

// same-cycle implication
`define MKA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MKA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mka_pkg.sv -----
package mka_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int TIME_BITS  = 20;
	localparam int US_BITS    = 20;
	localparam int CFG_W      = 20;
	localparam int CMP_W      = (TIME_BITS > US_BITS) ? TIME_BITS : US_BITS;
	localparam int CLAMP_W    = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TWO_PLAYERS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATE_PANEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT         = 2'd3;

	localparam logic [CFG_W-1:0] DEF_FIRST_DELAY = 20'd500000;
	localparam logic [CFG_W-1:0] DEF_REPEAT      = 20'd50000;

	localparam int DIR_UP    = 0;
	localparam int DIR_DOWN  = 1;
	localparam int DIR_LEFT  = 2;
	localparam int DIR_RIGHT = 3;
	localparam int KEY_START   = 4;
	localparam int KEY_SERVICE = 5;
	localparam int SYS_TEST   = 0;
	localparam int SYS_PANEL1 = 1;
	localparam int SYS_PANEL2 = 2;

	localparam logic [CLAMP_W-1:0] TIME_MAX_W = CLAMP_W'((64'd1 << TIME_BITS) - 64'd1);

	typedef struct packed {
		logic               clear;
		logic [US_BITS-1:0] elapsed_us;
		logic [2:0]         sys_pressed;
		logic [5:0]         p1_pressed;
		logic [5:0]         p2_pressed;
		logic [3:0]         p1_held;
		logic [3:0]         p2_held;
	} poll_t;

	typedef struct packed {
		logic test_hit;
		logic service_hit;
		logic start_hit;
		logic up_hit;
		logic down_hit;
		logic left_hit;
		logic right_hit;
	} events_t;

	typedef struct packed {
		logic             two_players;
		logic             separate_panel_keys;
		logic [CFG_W-1:0] first_delay_us;
		logic [CFG_W-1:0] repeat_interval_us;
	} cfg_t;

	typedef struct packed {
		logic [NUM_TIMERS-1:0] active;
		logic [NUM_TIMERS-1:0] zero;
	} timer_status_t;

	typedef struct packed {
		logic [NUM_TIMERS-1:0] active;
		logic [NUM_TIMERS-1:0] load_first;
		logic [NUM_TIMERS-1:0] load_repeat;
	} timer_update_t;

	function automatic logic [TIME_BITS-1:0] clamp_time(input logic [CFG_W-1:0] v);
		logic [CLAMP_W-1:0] w;
		w = CLAMP_W'(v);
		if (w > TIME_MAX_W)
			return TIME_BITS'(TIME_MAX_W);
		return TIME_BITS'(w);
	endfunction

endpackage

// ----- hdl/mka_timers.sv -----
module mka_timers (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         clear,
	input  logic [mka_pkg::US_BITS-1:0]  elapsed_us,
	input  mka_pkg::cfg_t                cfg,
	input  mka_pkg::timer_update_t       upd,
	output mka_pkg::timer_status_t       status
);
	import mka_pkg::*;

	logic [NUM_TIMERS-1:0] active_q;
	logic [TIME_BITS-1:0]  remaining_q [NUM_TIMERS];
	logic [TIME_BITS-1:0]  remaining_d [NUM_TIMERS];
	logic [CMP_W-1:0]      rem_w [NUM_TIMERS];
	logic [CMP_W-1:0]      el_w;

	assign el_w = CMP_W'(elapsed_us);

	// count down armed timers, saturating at zero
	always_comb begin
		for (int k = 0; k < NUM_TIMERS; k++) begin
			rem_w[k] = CMP_W'(remaining_q[k]);
			status.active[k] = active_q[k] & ~clear;
			if (status.active[k]) begin
				remaining_d[k] = (rem_w[k] > el_w) ? TIME_BITS'(rem_w[k] - el_w) : '0;
			end else begin
				remaining_d[k] = remaining_q[k];
			end
			status.zero[k] = (remaining_d[k] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (advance) begin
			active_q <= upd.active;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				if (upd.load_repeat[k]) begin
					remaining_q[k] <= clamp_time(cfg.repeat_interval_us);
				end else if (upd.load_first[k]) begin
					remaining_q[k] <= clamp_time(cfg.first_delay_us);
				end else begin
					remaining_q[k] <= remaining_d[k];
				end
			end
		end
	end

endmodule

// ----- hdl/mka_events.sv -----
module mka_events (
	input  mka_pkg::poll_t          poll,
	input  mka_pkg::cfg_t           cfg,
	input  mka_pkg::timer_status_t  status,
	output mka_pkg::events_t        ev,
	output mka_pkg::timer_update_t  upd
);
	import mka_pkg::*;

	logic                  two;
	logic                  joined;
	logic                  first_zero;
	logic [NUM_TIMERS-1:0] held;
	logic [NUM_TIMERS-1:0] arm;
	logic [NUM_TIMERS-1:0] act2;
	logic [NUM_TIMERS-1:0] zero2;
	logic [NUM_TIMERS-1:0] fire;
	logic [NUM_TIMERS-1:0] run;
	logic [3:0]            dir_hit;

	assign two        = cfg.two_players;
	assign joined     = ~cfg.separate_panel_keys;
	assign first_zero = (clamp_time(cfg.first_delay_us) == '0);

	always_comb begin
		for (int k = 0; k < NUM_TIMERS; k++) begin
			held[k] = k[0] ? poll.p2_held[k >> 1] : poll.p1_held[k >> 1];
		end
	end

	always_comb begin
		int  da;
		int  db;
		int  ta;
		int  tb;
		logic a1;
		logic a2;
		logic b1;
		logic b2;
		logic rep_a;

		da         = 0;
		db         = 0;
		ta         = 0;
		tb         = 0;
		a1         = 1'b0;
		a2         = 1'b0;
		b1         = 1'b0;
		b2         = 1'b0;
		rep_a      = 1'b0;
		ev         = '0;
		dir_hit    = '0;
		arm        = '0;
		run        = '0;
		act2       = status.active;
		zero2      = status.zero;
		fire       = '0;
		upd.active      = status.active;
		upd.load_first  = '0;
		upd.load_repeat = '0;

		if (poll.sys_pressed[SYS_TEST] || (joined && poll.sys_pressed[SYS_PANEL1])) begin
			ev.test_hit = 1'b1;
		end else if (poll.p1_pressed[KEY_SERVICE] || (joined && poll.sys_pressed[SYS_PANEL2]) ||
				(two && poll.p2_pressed[KEY_SERVICE])) begin
			ev.service_hit = 1'b1;
		end else if (poll.p1_pressed[KEY_START] || (two && poll.p2_pressed[KEY_START])) begin
			ev.start_hit = 1'b1;
		end else begin
			for (int ax = 0; ax < 2; ax++) begin
				da = 2 * ax;
				db = 2 * ax + 1;
				ta = 2 * da;
				tb = 2 * db;
				a1 = poll.p1_pressed[da];
				a2 = poll.p2_pressed[da];
				b1 = poll.p1_pressed[db];
				b2 = poll.p2_pressed[db];
				if (a1 || (two && a2)) begin
					dir_hit[da] = 1'b1;
					arm[ta]     = a1;
					arm[ta + 1] = a2;
				end else if (b1 || (two && b2)) begin
					dir_hit[db] = 1'b1;
					arm[tb]     = b1;
					arm[tb + 1] = b2;
				end
			end

			for (int k = 0; k < NUM_TIMERS; k++) begin
				act2[k]  = status.active[k] | arm[k];
				zero2[k] = arm[k] ? first_zero : status.zero[k];
				fire[k]  = act2[k] & held[k] & zero2[k];
			end

			// on each axis, repeat checks stop at the first one that fires
			for (int ax = 0; ax < 2; ax++) begin
				da = 2 * ax;
				db = 2 * ax + 1;
				ta = 2 * da;
				tb = 2 * db;
				run[ta]     = 1'b1;
				run[ta + 1] = two & ~fire[ta];
				rep_a       = fire[ta] | (run[ta + 1] & fire[ta + 1]);
				run[tb]     = ~rep_a;
				run[tb + 1] = ~rep_a & ~fire[tb] & two;
				if (rep_a) begin
					dir_hit[da] = 1'b1;
				end else if (fire[tb] || (run[tb + 1] && fire[tb + 1])) begin
					dir_hit[db] = 1'b1;
				end
			end

			for (int k = 0; k < NUM_TIMERS; k++) begin
				upd.active[k]      = act2[k] & ~(run[k] & ~held[k]);
				upd.load_first[k]  = arm[k];
				upd.load_repeat[k] = run[k] & fire[k];
			end
		end

		ev.up_hit    = dir_hit[DIR_UP];
		ev.down_hit  = dir_hit[DIR_DOWN];
		ev.left_hit  = dir_hit[DIR_LEFT];
		ev.right_hit = dir_hit[DIR_RIGHT];
	end

endmodule

// ----- hdl/menu_key_autorepeat_unit.sv -----
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_data  (poll_t)
// out       output     out_valid / out_ready   out_data (events_t)
// cfg       input      cfg_we                  cfg_index, cfg_wdata
//
// One poll per cycle while out_ready is high; each poll goes through the
// input register, then its result through the result register, with timers
// updated as the poll moves from the input to the result register.
// Reset disarms all timers and loads the register defaults.
// While out_ready is low the result is held and one more poll waits in
// the input register.
`include "menu_key_autorepeat_unit_assert.svh"

module menu_key_autorepeat_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  mka_pkg::poll_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output mka_pkg::events_t                out_data,
	input  logic                            cfg_we,
	input  logic [mka_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mka_pkg::CFG_W-1:0]       cfg_wdata
);
	import mka_pkg::*;

	cfg_t          cfg_q;
	poll_t         poll_s1;
	logic          valid_s1;
	events_t       result_s2;
	logic          result_valid_s2;
	logic          advance;
	events_t       ev;
	timer_status_t status;
	timer_update_t upd;
	logic [2:0]    sys_ev;
	logic [3:0]    dir_ev;

	assign advance   = valid_s1 & (~result_valid_s2 | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = result_valid_s2;
	assign out_data  = result_s2;
	assign sys_ev    = {out_data.test_hit, out_data.service_hit, out_data.start_hit};
	assign dir_ev    = {out_data.up_hit, out_data.down_hit, out_data.left_hit,
		out_data.right_hit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_players         <= 1'b1;
			cfg_q.separate_panel_keys <= 1'b0;
			cfg_q.first_delay_us      <= DEF_FIRST_DELAY;
			cfg_q.repeat_interval_us  <= DEF_REPEAT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TWO_PLAYERS:    cfg_q.two_players         <= cfg_wdata[0];
				REG_SEPARATE_PANEL: cfg_q.separate_panel_keys <= cfg_wdata[0];
				REG_FIRST_DELAY:    cfg_q.first_delay_us      <= cfg_wdata;
				REG_REPEAT:         cfg_q.repeat_interval_us  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			result_valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				result_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				result_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			poll_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= ev;
		end
	end

	mka_timers u_timers (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.clear      (poll_s1.clear),
		.elapsed_us (poll_s1.elapsed_us),
		.cfg        (cfg_q),
		.upd        (upd),
		.status     (status)
	);

	mka_events u_events (
		.poll   (poll_s1),
		.cfg    (cfg_q),
		.status (status),
		.ev     (ev),
		.upd    (upd)
	);

	`MKA_ASSERT_IMP(a_key_excl, out_valid && |sys_ev, $onehot(sys_ev) && !(|dir_ev), "key mixed")
	`MKA_ASSERT_IMP(a_stall, !in_ready, valid_s1 && result_valid_s2 && !out_ready, "bad stall")
	`MKA_ASSERT_NXT(a_advance, advance, result_valid_s2, "advanced poll gave no result")

endmodule

// ----- sim/menu_key_autorepeat_unit_test.sv -----
module menu_key_autorepeat_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mka_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 65;
	localparam logic [CFG_W-1:0] DELAY_MAX = '1;

	localparam events_t EV_NONE    = 7'b0000000;
	localparam events_t EV_TEST    = 7'b1000000;
	localparam events_t EV_SERVICE = 7'b0100000;
	localparam events_t EV_START   = 7'b0010000;
	localparam events_t EV_UP      = 7'b0001000;

	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
		poll_t                p;
		bit                   typed;
		events_t              want;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	poll_t                in_data;
	logic                 out_valid;
	logic                 out_ready;
	events_t              out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	bit                   nav_two = 1'b1;
	bit                   panel_split = 1'b0;
	logic [CFG_W-1:0]     delay_first = DEF_FIRST_DELAY;
	logic [CFG_W-1:0]     delay_repeat = DEF_REPEAT;
	bit                   rpt_armed [NUM_TIMERS];
	logic [TIME_BITS-1:0] rpt_left [NUM_TIMERS];

	events_t              pending_events [$];
	step_row_t            step_rows [$];
	int                   errors = 0;
	bit                   send_gaps = 1'b1;
	bit                   stall_gaps = 1'b1;
	bit                   row_typed = 1'b0;
	events_t              row_want = EV_NONE;
	logic [3:0]           hold1 = 4'b0;
	logic [3:0]           hold2 = 4'b0;
	logic [CFG_W-1:0]     ph_first;
	logic [CFG_W-1:0]     ph_repeat;

	menu_key_autorepeat_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		errors++;
	endtask

	task automatic check_hit(input string field, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s got %b expected %b", field, got, want));
	endtask

	task automatic check_events(input events_t got, input events_t want);
		check_hit("test_hit", got.test_hit, want.test_hit);
		check_hit("service_hit", got.service_hit, want.service_hit);
		check_hit("start_hit", got.start_hit, want.start_hit);
		check_hit("up_hit", got.up_hit, want.up_hit);
		check_hit("down_hit", got.down_hit, want.down_hit);
		check_hit("left_hit", got.left_hit, want.left_hit);
		check_hit("right_hit", got.right_hit, want.right_hit);
	endtask

	function automatic void arm_timer(input int k);
		rpt_armed[k] = 1'b1;
		rpt_left[k] = TIME_BITS'(delay_first);
	endfunction

	function automatic bit repeat_due(input int k, input logic held);
		if (!rpt_armed[k])
			return 1'b0;
		if (!held) begin
			rpt_armed[k] = 1'b0;
			return 1'b0;
		end
		if (rpt_left[k] == '0) begin
			rpt_left[k] = TIME_BITS'(delay_repeat);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void scan_axis(input int da, input int db, input poll_t p,
			output bit hit_a, output bit hit_b);
		int ta;
		int tb;
		bit fired;
		hit_a = 1'b0;
		hit_b = 1'b0;
		ta = da * 2;
		tb = db * 2;
		if (p.p1_pressed[da] || (nav_two && p.p2_pressed[da])) begin
			hit_a = 1'b1;
			if (p.p1_pressed[da])
				arm_timer(ta);
			if (p.p2_pressed[da])
				arm_timer(ta + 1);
		end else if (p.p1_pressed[db] || (nav_two && p.p2_pressed[db])) begin
			hit_b = 1'b1;
			if (p.p1_pressed[db])
				arm_timer(tb);
			if (p.p2_pressed[db])
				arm_timer(tb + 1);
		end
		fired = repeat_due(ta, p.p1_held[da]);
		if (!fired && nav_two)
			fired = repeat_due(ta + 1, p.p2_held[da]);
		if (fired) begin
			hit_a = 1'b1;
		end else begin
			fired = repeat_due(tb, p.p1_held[db]);
			if (!fired && nav_two)
				fired = repeat_due(tb + 1, p.p2_held[db]);
			if (fired)
				hit_b = 1'b1;
		end
	endfunction

	function automatic events_t predict_events(input poll_t p);
		events_t ev;
		bit joined;
		bit ha;
		bit hb;
		ev = EV_NONE;
		joined = !panel_split;
		for (int k = 0; k < NUM_TIMERS; k++) begin
			if (p.clear)
				rpt_armed[k] = 1'b0;
			if (rpt_armed[k])
				rpt_left[k] = (rpt_left[k] > p.elapsed_us) ? rpt_left[k] - p.elapsed_us : '0;
		end
		if (p.sys_pressed[SYS_TEST] || (joined && p.sys_pressed[SYS_PANEL1])) begin
			ev.test_hit = 1'b1;
		end else if (p.p1_pressed[KEY_SERVICE] || (joined && p.sys_pressed[SYS_PANEL2]) ||
				(nav_two && p.p2_pressed[KEY_SERVICE])) begin
			ev.service_hit = 1'b1;
		end else if (p.p1_pressed[KEY_START] || (nav_two && p.p2_pressed[KEY_START])) begin
			ev.start_hit = 1'b1;
		end else begin
			scan_axis(DIR_UP, DIR_DOWN, p, ha, hb);
			ev.up_hit = ha;
			ev.down_hit = hb;
			scan_axis(DIR_LEFT, DIR_RIGHT, p, ha, hb);
			ev.left_hit = ha;
			ev.right_hit = hb;
		end
		return ev;
	endfunction

	always @(posedge clk) begin : watch
		events_t ev;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0)
					report_mismatch($sformatf("result %b with none expected", out_data));
				else
					check_events(out_data, pending_events.pop_front());
			end
			if (in_valid && in_ready) begin
				ev = predict_events(in_data);
				pending_events.push_back(row_typed ? row_want : ev);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TWO_PLAYERS:    nav_two = cfg_wdata[0];
					REG_SEPARATE_PANEL: panel_split = cfg_wdata[0];
					REG_FIRST_DELAY:    delay_first = cfg_wdata;
					REG_REPEAT:         delay_repeat = cfg_wdata;
					default:            ;
				endcase
			end
		end
	end

	always @(negedge clk) begin
		out_ready = !stall_gaps || ($urandom_range(0, 99) >= 20);
	end

	task automatic send_poll(input poll_t p, input bit typed, input events_t want);
		while (send_gaps && $urandom_range(0, 99) < 20) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = p;
		row_typed = typed;
		row_want = want;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		in_valid = 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic poll_t poll_of(input bit clr, input logic [US_BITS-1:0] el,
			input logic [2:0] sys, input logic [5:0] p1p, input logic [5:0] p2p,
			input logic [3:0] p1h, input logic [3:0] p2h);
		poll_t p;
		p.clear = clr;
		p.elapsed_us = el;
		p.sys_pressed = sys;
		p.p1_pressed = p1p;
		p.p2_pressed = p2p;
		p.p1_held = p1h;
		p.p2_held = p2h;
		return p;
	endfunction

	task automatic add_poll(input poll_t p, input bit typed, input events_t want);
		step_row_t r;
		r.is_reg = 1'b0;
		r.idx = REG_TWO_PLAYERS;
		r.val = '0;
		r.p = p;
		r.typed = typed;
		r.want = want;
		step_rows.push_back(r);
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		step_row_t r;
		r.is_reg = 1'b1;
		r.idx = idx;
		r.val = val;
		r.p = '0;
		r.typed = 1'b0;
		r.want = EV_NONE;
		step_rows.push_back(r);
	endtask

	function automatic logic [CFG_W-1:0] pick_delay();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 20'd1;
			2:       return DELAY_MAX;
			3, 4:    return CFG_W'($urandom_range(1, 3000));
			default: return CFG_W'($urandom_range(1, 20'hFFFFF));
		endcase
	endfunction

	function automatic poll_t next_poll();
		poll_t p;
		logic [3:0] prev1;
		logic [3:0] prev2;
		int span;
		if ($urandom_range(0, 99) < 10) begin
			p.clear = 1'($urandom_range(0, 1));
			p.elapsed_us = US_BITS'($urandom_range(0, 20'hFFFFF));
			p.sys_pressed = 3'($urandom_range(0, 7));
			p.p1_pressed = 6'($urandom_range(0, 63));
			p.p2_pressed = 6'($urandom_range(0, 63));
			p.p1_held = 4'($urandom_range(0, 15));
			p.p2_held = 4'($urandom_range(0, 15));
			return p;
		end
		prev1 = hold1;
		prev2 = hold2;
		if ($urandom_range(0, 99) < 25)
			hold1 = hold1 ^ (4'b0001 << $urandom_range(0, 3));
		if ($urandom_range(0, 99) < 25)
			hold2 = hold2 ^ (4'b0001 << $urandom_range(0, 3));
		p.clear = ($urandom_range(0, 99) < 3);
		p.sys_pressed = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(1, 7)) : 3'b000;
		p.p1_pressed[5:4] = ($urandom_range(0, 99) < 4) ? 2'($urandom_range(1, 3)) : 2'b00;
		p.p2_pressed[5:4] = ($urandom_range(0, 99) < 4) ? 2'($urandom_range(1, 3)) : 2'b00;
		p.p1_pressed[3:0] = hold1 & ~prev1;
		p.p2_pressed[3:0] = hold2 & ~prev2;
		if ($urandom_range(0, 99) < 5)
			p.p1_pressed[3:0] = p.p1_pressed[3:0] | 4'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 5)
			p.p2_pressed[3:0] = p.p2_pressed[3:0] | 4'($urandom_range(0, 15));
		p.p1_held = hold1;
		p.p2_held = hold2;
		span = ((ph_first > ph_repeat) ? int'(ph_first) : int'(ph_repeat)) / 2 + 1;
		case ($urandom_range(0, 9))
			0, 1:    p.elapsed_us = '0;
			2:       p.elapsed_us = '1;
			3:       p.elapsed_us = US_BITS'($urandom_range(0, 20'hFFFFF));
			default: p.elapsed_us = US_BITS'($urandom_range(0, span));
		endcase
		return p;
	endfunction

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		step_row_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TWO_PLAYERS;
		cfg_wdata = '0;
		for (int k = 0; k < NUM_TIMERS; k++) begin
			rpt_armed[k] = 1'b0;
			rpt_left[k] = '0;
		end

		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h00, 4'h0, 4'h0), 1, EV_NONE);
		add_poll(poll_of(0, 0, 3'b001, 6'h00, 6'h00, 4'h0, 4'h0), 1, EV_TEST);
		add_poll(poll_of(0, 0, 3'b010, 6'h00, 6'h00, 4'h0, 4'h0), 1, EV_TEST);
		add_poll(poll_of(0, 0, 3'b100, 6'h00, 6'h00, 4'h0, 4'h0), 1, EV_SERVICE);
		add_poll(poll_of(0, 0, 3'b000, 6'h20, 6'h00, 4'h0, 4'h0), 1, EV_SERVICE);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h20, 4'h0, 4'h0), 1, EV_SERVICE);
		add_poll(poll_of(0, 0, 3'b000, 6'h10, 6'h00, 4'h0, 4'h0), 1, EV_START);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h10, 4'h0, 4'h0), 1, EV_START);
		add_poll(poll_of(1, '1, 3'b111, 6'h3F, 6'h3F, 4'hF, 4'hF), 1, EV_TEST);
		add_poll(poll_of(0, 0, 3'b000, 6'h01, 6'h00, 4'h1, 4'h0), 1, EV_UP);
		add_poll(poll_of(0, 500000, 3'b000, 6'h00, 6'h00, 4'h1, 4'h0), 0, EV_NONE);
		add_poll(poll_of(0, '1, 3'b000, 6'h00, 6'h00, 4'h1, 4'h0), 0, EV_NONE);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h00, 4'h0, 4'h0), 0, EV_NONE);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h02, 4'h0, 4'h2), 0, EV_NONE);
		add_poll(poll_of(0, 0, 3'b000, 6'h04, 6'h00, 4'h4, 4'h2), 0, EV_NONE);
		add_poll(poll_of(0, '1, 3'b000, 6'h08, 6'h00, 4'hC, 4'h2), 0, EV_NONE);
		add_poll(poll_of(1, '1, 3'b000, 6'h00, 6'h00, 4'hC, 4'h2), 0, EV_NONE);
		add_reg(REG_TWO_PLAYERS, 20'd0);
		add_reg(REG_SEPARATE_PANEL, 20'd1);
		add_reg(REG_FIRST_DELAY, 20'd0);
		add_reg(REG_REPEAT, 20'd0);
		add_poll(poll_of(0, 0, 3'b010, 6'h00, 6'h00, 4'h0, 4'h0), 1, EV_NONE);
		add_poll(poll_of(0, 0, 3'b100, 6'h00, 6'h00, 4'h0, 4'h0), 1, EV_NONE);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h30, 4'h0, 4'h0), 1, EV_NONE);
		add_poll(poll_of(0, 0, 3'b000, 6'h01, 6'h01, 4'h1, 4'h1), 0, EV_NONE);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h00, 4'h0, 4'h1), 0, EV_NONE);
		add_reg(REG_TWO_PLAYERS, 20'd1);
		add_poll(poll_of(0, 0, 3'b000, 6'h00, 6'h00, 4'h0, 4'h1), 0, EV_NONE);
		add_reg(REG_SEPARATE_PANEL, 20'd0);
		add_reg(REG_FIRST_DELAY, DELAY_MAX);
		add_reg(REG_REPEAT, 20'd1);
		add_poll(poll_of(0, 0, 3'b000, 6'h08, 6'h00, 4'h8, 4'h0), 0, EV_NONE);
		add_poll(poll_of(0, '1, 3'b000, 6'h00, 6'h00, 4'h8, 4'h0), 0, EV_NONE);
		add_poll(poll_of(0, 1, 3'b000, 6'h00, 6'h00, 4'h8, 4'h0), 0, EV_NONE);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (step_rows[i]) begin
			r = step_rows[i];
			if (r.is_reg) begin
				wait_quiet();
				write_reg(r.idx, r.val);
			end else begin
				send_poll(r.p, r.typed, r.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_quiet();
			send_gaps = (ph != 2);
			stall_gaps = (ph != 2);
			ph_first = pick_delay();
			ph_repeat = pick_delay();
			write_reg(REG_TWO_PLAYERS, CFG_W'($urandom_range(0, 1)));
			write_reg(REG_SEPARATE_PANEL, CFG_W'($urandom_range(0, 1)));
			write_reg(REG_FIRST_DELAY, ph_first);
			write_reg(REG_REPEAT, ph_repeat);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 5 && n == PHASE_ITEMS / 2)
					wait_quiet();
				send_poll(next_poll(), 1'b0, EV_NONE);
			end
		end

		in_valid = 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
